>>> src/bmp_pkg.sv
package bmp_pkg;

  localparam int unsigned ModW = 31;
  localparam int unsigned IdxW = 20;
  localparam logic [ModW-1:0] ModulusReset = 31'd1000000007;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FACT_MUL,
    ST_FACT_WAIT,
    ST_DEN_MUL,
    ST_DEN_WAIT,
    ST_POW_ACC,
    ST_POW_ACC_WAIT,
    ST_POW_SQR,
    ST_POW_SQR_WAIT,
    ST_FIN_MUL,
    ST_FIN_WAIT,
    ST_OUT
  } bmp_state_e;

  typedef enum logic [2:0] {
    MS_FACT,
    MS_DEN,
    MS_ACC,
    MS_SQR,
    MS_FIN
  } bmp_msel_e;

  typedef struct packed {
    logic       load;
    logic       mul_start;
    bmp_msel_e  msel;
    logic       step_i;
    logic       shift_e;
    logic       out_valid;
  } bmp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic invalid;
    logic trivial;
    logic fact_last;
    logic exp_zero;
    logic exp_bit;
  } bmp_sts_t;

endpackage

>>> src/binomial_mod_prime_core.sv
// channel   dir  fields (tdata/tuser, low bit first)
// s_axis    in   tdata: n_value[19:0], k_value[39:20]
// m_axis    out  tdata: coefficient[30:0]; tuser: invalid
// cfg       in   modulus[30:0], write when cfg_we_i
//
// one request at a time through a shared bit-serial mod multiplier
// async active-low reset restores modulus 1000000007 and idles the controller
// result is held on m_axis until taken; a new request waits until then
module binomial_mod_prime_core #(
  parameter int unsigned MaxN = 1048575
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // n_value, k_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // coefficient, zero pad
  output logic        m_axis_tuser,  // invalid
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);
  import bmp_pkg::*;

  logic [ModW-1:0] modulus_q;
  bmp_cmd_t cmd;
  bmp_sts_t sts;
  logic [ModW-1:0] coef;
  logic inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  bmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmp_datapath #(.MaxN(MaxN)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .n_i      (s_axis_tdata[IdxW-1:0]),
    .k_i      (s_axis_tdata[2*IdxW-1:IdxW]),
    .m_i      (modulus_q),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .coef_o   (coef),
    .invalid_o(inv)
  );

  assign m_axis_tvalid = cmd.out_valid;
  assign m_axis_tdata = {1'b0, coef};
  assign m_axis_tuser = inv;

endmodule

>>> src/bmp_mulmod.sv
module bmp_mulmod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bmp_pkg::ModW-1:0] a_i,
  input  logic [bmp_pkg::ModW-1:0] b_i,
  input  logic [bmp_pkg::ModW-1:0] m_i,
  output logic [bmp_pkg::ModW-1:0] p_o,
  output logic                     done_o
);
  import bmp_pkg::*;

  localparam int unsigned ProdW = 2 * ModW;
  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic [ModW-1:0] a_q, a_d;
  logic [ModW-1:0] b_q, b_d;
  logic [ModW-1:0] r_q, r_d;
  logic [ModW-1:0] m_q, m_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [1:0] phase_q, phase_d;
  logic [CntW-1:0] bit_idx;
  logic [ModW:0] shl;
  logic [ModW:0] sub;

  always_comb begin
    bit_idx = CntW'(ProdW - 1) - cnt_q;
    shl = {r_q, prod_q[bit_idx]};
    sub = shl - {1'b0, m_q};
  end

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    m_d = m_q;
    r_d = r_q;
    prod_d = prod_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    phase_d = phase_q;
    if (start_i) begin
      a_d = a_i;
      b_d = b_i;
      m_d = m_i;
      busy_d = 1'b1;
      phase_d = 2'd0;
    end else if (busy_q) begin
      unique case (phase_q)
        2'd0: begin
          prod_d = ProdW'(a_q) * ProdW'(b_q);
          r_d = '0;
          cnt_d = '0;
          phase_d = 2'd1;
        end
        default: begin
          if (shl >= {1'b0, m_q}) begin
            r_d = sub[ModW-1:0];
          end else begin
            r_d = shl[ModW-1:0];
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(ProdW - 1)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      phase_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
    r_q <= r_d;
    prod_q <= prod_d;
  end

  assign p_o = r_q;
  assign done_o = done_q;

endmodule

>>> src/bmp_datapath.sv
module bmp_datapath #(
  parameter int unsigned MaxN = 1048575
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bmp_pkg::IdxW-1:0] n_i,
  input  logic [bmp_pkg::IdxW-1:0] k_i,
  input  logic [bmp_pkg::ModW-1:0] m_i,
  input  bmp_pkg::bmp_cmd_t        cmd_i,
  output bmp_pkg::bmp_sts_t        sts_o,
  output logic [bmp_pkg::ModW-1:0] coef_o,
  output logic                     invalid_o
);
  import bmp_pkg::*;

  logic [IdxW-1:0] n_q, k_q, nk_q;
  logic [IdxW:0] i_q;
  logic [ModW-1:0] m_q, fact_q, fk_q, fnk_q, base_q, acc_q, e_q, res_q, im_q;
  logic inv_q;
  logic [ModW-1:0] ma, mb, mp;
  logic mdone;
  logic [ModW:0] im_inc;

  always_comb begin
    unique case (cmd_i.msel)
      MS_FACT: begin ma = fact_q; mb = im_q; end
      MS_DEN:  begin ma = fk_q;   mb = fnk_q; end
      MS_ACC:  begin ma = acc_q;  mb = base_q; end
      MS_SQR:  begin ma = base_q; mb = base_q; end
      MS_FIN:  begin ma = fact_q; mb = acc_q; end
      default: begin ma = fact_q; mb = acc_q; end
    endcase
  end

  bmp_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (ma),
    .b_i    (mb),
    .m_i    (m_q),
    .p_o    (mp),
    .done_o (mdone)
  );

  assign im_inc = {1'b0, im_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (cmd_i.load) begin
      inv_q <= (k_i > n_i) || (32'(n_i) > 32'(MaxN));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= n_i;
      k_q <= k_i;
      nk_q <= n_i - k_i;
      m_q <= m_i;
      i_q <= (IdxW+1)'(1);
      im_q <= (m_i == ModW'(1)) ? '0 : ModW'(1);
      fact_q <= ModW'(1);
      fk_q <= ModW'(1);
      fnk_q <= ModW'(1);
      acc_q <= ModW'(1);
      e_q <= m_i - ModW'(2);
      res_q <= '0;
    end else begin
      if (mdone) begin
        unique case (cmd_i.msel)
          MS_FACT: begin
            fact_q <= mp;
            if (i_q == {1'b0, k_q}) fk_q <= mp;
            if (i_q == {1'b0, nk_q}) fnk_q <= mp;
          end
          MS_DEN: base_q <= mp;
          MS_ACC: acc_q <= mp;
          MS_SQR: base_q <= mp;
          MS_FIN: res_q <= mp;
          default: res_q <= mp;
        endcase
      end
      if (cmd_i.step_i) begin
        i_q <= i_q + 1'b1;
        im_q <= (im_inc >= {1'b0, m_q}) ? '0 : im_inc[ModW-1:0];
      end
      if (cmd_i.shift_e) e_q <= e_q >> 1;
    end
  end

  assign sts_o.mul_done = mdone;
  assign sts_o.invalid = inv_q;
  assign sts_o.trivial = (m_q < ModW'(2));
  assign sts_o.fact_last = (i_q > {1'b0, n_q});
  assign sts_o.exp_zero = (e_q == '0);
  assign sts_o.exp_bit = e_q[0];
  assign coef_o = (inv_q || m_q < ModW'(2)) ? '0 : res_q;
  assign invalid_o = inv_q;

endmodule

>>> src/bmp_ctrl.sv
module bmp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  input  bmp_pkg::bmp_sts_t  sts_i,
  output bmp_pkg::bmp_cmd_t  cmd_o
);
  import bmp_pkg::*;

  bmp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.invalid || sts_i.trivial) state_d = ST_OUT;
        else if (sts_i.fact_last) state_d = ST_DEN_MUL;
        else state_d = ST_FACT_MUL;
      end
      ST_FACT_MUL: state_d = ST_FACT_WAIT;
      ST_FACT_WAIT: if (sts_i.mul_done) state_d = ST_CHECK;
      ST_DEN_MUL: state_d = ST_DEN_WAIT;
      ST_DEN_WAIT: if (sts_i.mul_done) state_d = ST_POW_ACC;
      ST_POW_ACC: begin
        if (sts_i.exp_zero) state_d = ST_FIN_MUL;
        else if (sts_i.exp_bit) state_d = ST_POW_ACC_WAIT;
        else state_d = ST_POW_SQR;
      end
      ST_POW_ACC_WAIT: if (sts_i.mul_done) state_d = ST_POW_SQR;
      ST_POW_SQR: state_d = ST_POW_SQR_WAIT;
      ST_POW_SQR_WAIT: if (sts_i.mul_done) state_d = ST_POW_ACC;
      ST_FIN_MUL: state_d = ST_FIN_WAIT;
      ST_FIN_WAIT: if (sts_i.mul_done) state_d = ST_OUT;
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{load: 1'b0, mul_start: 1'b0, msel: MS_FACT, step_i: 1'b0,
              shift_e: 1'b0, out_valid: 1'b0};
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_FACT_MUL: begin
        cmd_o.mul_start = 1'b1;
      end
      ST_FACT_WAIT: cmd_o.step_i = sts_i.mul_done;
      ST_DEN_MUL: begin
        cmd_o.msel = MS_DEN;
        cmd_o.mul_start = 1'b1;
      end
      ST_DEN_WAIT: cmd_o.msel = MS_DEN;
      ST_POW_ACC: begin
        cmd_o.msel = MS_ACC;
        cmd_o.mul_start = !sts_i.exp_zero && sts_i.exp_bit;
      end
      ST_POW_ACC_WAIT: cmd_o.msel = MS_ACC;
      ST_POW_SQR: begin
        cmd_o.msel = MS_SQR;
        cmd_o.mul_start = 1'b1;
      end
      ST_POW_SQR_WAIT: begin
        cmd_o.msel = MS_SQR;
        cmd_o.shift_e = sts_i.mul_done;
      end
      ST_FIN_MUL: begin
        cmd_o.msel = MS_FIN;
        cmd_o.mul_start = 1'b1;
      end
      ST_FIN_WAIT: cmd_o.msel = MS_FIN;
      ST_OUT: cmd_o.out_valid = 1'b1;
      default: cmd_o.out_valid = 1'b0;
    endcase
  end

endmodule

>>> tb/tb.sv
module tb;
  import bmp_pkg::*;

  localparam longint unsigned CycleLimit = 4000000;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    logic [ModW-1:0] coefficient;
    logic            invalid;
  } binom_result_t;

  class binom_scoreboard;
    binom_result_t pending_q[$];
    int unsigned   mismatches;

    function longint unsigned mod_mul(longint unsigned x, longint unsigned y,
                                      longint unsigned m);
      return (x * y) % m;
    endfunction

    function longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                      longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      b = b % m;
      while (e != 0) begin
        if (e[0]) acc = mod_mul(acc, b, m);
        b = mod_mul(b, b, m);
        e = e >> 1;
      end
      return acc;
    endfunction

    function binom_result_t binomial_residue(logic [IdxW-1:0] n, logic [IdxW-1:0] k,
                                             logic [ModW-1:0] modulus);
      binom_result_t   r;
      longint unsigned m, fact, fk, fnk, den;
      m = modulus;
      r.coefficient = '0;
      r.invalid = 1'b0;
      if (k > n) begin
        r.invalid = 1'b1;
        return r;
      end
      if (m < 2) return r;
      fact = 1;
      fk = 1;
      fnk = 1;
      for (longint unsigned i = 1; i <= n; i++) begin
        fact = mod_mul(fact, i % m, m);
        if (i == k) fk = fact;
        if (i == n - k) fnk = fact;
      end
      den = mod_mul(fk, fnk, m);
      r.coefficient = ModW'(mod_mul(fact, mod_pow(den, m - 2, m), m));
      return r;
    endfunction

    function void note_request(logic [IdxW-1:0] n, logic [IdxW-1:0] k,
                               logic [ModW-1:0] modulus);
      pending_q.push_back(binomial_residue(n, k, modulus));
    endfunction

    function void check_result(logic [ModW-1:0] coefficient, logic invalid);
      binom_result_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result coefficient=%0d invalid=%0b", coefficient, invalid);
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r.coefficient !== coefficient || exp_r.invalid !== invalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp coefficient=%0d invalid=%0b, got coefficient=%0d invalid=%0b",
                   exp_r.coefficient, exp_r.invalid, coefficient, invalid);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [30:0] cfg_wdata_i;

  binom_scoreboard binom_sb;
  logic [ModW-1:0] cur_modulus;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  longint unsigned cycle_count;

  binomial_mod_prime_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[binomial_mod_prime_core] ERROR");
      $finish;
    end
  end

  // result side: random backpressure and checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        binom_sb.check_result(m_axis_tdata[ModW-1:0], m_axis_tuser);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [IdxW-1:0] n, logic [IdxW-1:0] k);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {k, n};
    do @(posedge clk_i); while (!s_axis_tready);
    binom_sb.note_request(n, k, cur_modulus);
  endtask

  task automatic send_random_request();
    logic [IdxW-1:0] n, k;
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(1, 20'hFFFFF);
      n = $urandom_range(0, k - 1);
    end else begin
      n = $urandom_range(0, 40);
      k = $urandom_range(0, n);
    end
    send_request(n, k);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (binom_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [ModW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_modulus = value;
    @(posedge clk_i);
  endtask

  logic [ModW-1:0] phase_modulus [8];

  initial begin
    binom_sb = new();
    cycle_count = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cur_modulus = ModulusReset;
    send_idle_pct = 25;
    recv_idle_pct = 83;
    phase_modulus = '{ModulusReset, 31'd2, 31'h7FFFFFFF, 31'd1, 31'd0, 31'd13,
                      31'd9, 31'd1000000007};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge cases and random requests at the reset modulus
    send_request(0, 0);
    send_request(1, 0);
    send_request(1, 1);
    send_request(5, 0);
    send_request(5, 5);
    send_request(10, 3);
    send_request(40, 20);
    send_request(3, 10);
    send_request(20'hFFFFE, 20'hFFFFF);
    send_request(20'h80001, 20'hFFFFF);
    send_request(0, 20'hFFFFF);
    send_request(20'h7FFFF, 20'h80000);
    for (int i = 0; i < 10; i++) send_random_request();
    settle();

    for (int p = 1; p < 8; p++) begin
      if (p < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 83;
      end else if (p < 6) begin
        send_idle_pct = 83;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_modulus(phase_modulus[p]);
      send_request(0, 0);
      send_request(20, 7);
      for (int i = 0; i < 10; i++) send_random_request();
      settle();
    end

    if (binom_sb.mismatches == 0 && binom_sb.pending_q.size() == 0) begin
      $display("[binomial_mod_prime_core] OK");
    end else begin
      $display("[binomial_mod_prime_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/bmp_pkg.sv
src/bmp_mulmod.sv
src/bmp_datapath.sv
src/bmp_ctrl.sv
src/binomial_mod_prime_core.sv
tb/tb.sv
